FILE: hw/rtl/pdmp_pkg.sv
// pdmp_pkg: shared constants, register codes and id mapping for the
// pixel depth to map point pipeline
// no dependencies
`timescale 1ns / 1ps

package pdmp_pkg;

	// parameter defaults
	localparam int COEF_FRAC_DEF  = 40;
	localparam int PIXEL_BITS_DEF = 12;
	localparam int DIST_BITS_DEF  = 16;

	// register file
	localparam int REG_W       = 64;
	localparam int COEF_W      = 32;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_X_XY   = 3'd0,
		REG_X_CO   = 3'd1,
		REG_Y_XY   = 3'd2,
		REG_Y_CO   = 3'd3,
		REG_BLUE   = 3'd4
	} cfg_reg_t;

	// fixed point
	localparam int Q16_BITS  = 16;
	localparam int CAP_BITS  = 40;
	localparam int COORD_W   = 24;
	localparam int FLIP_ONE  = 65536;
	localparam int OUT_MAX   = 8388607;
	localparam int OUT_MIN   = -8388608;

	// ids
	localparam int CLASS_W = 8;
	localparam int ID_W    = 8;
	localparam logic [ID_W-1:0] ID_OFFSET     = 8'd100;
	localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 8'd255;
	localparam logic [CLASS_W-1:0] CLASS_REMAP   = 8'd6;
	localparam logic [ID_W-1:0] ID_REMAP      = 8'd7;
	localparam logic [ID_W-1:0] ID_NONE       = 8'd0;

	localparam int OUT_TDATA_W = 2 * COORD_W + ID_W;

	function automatic logic [ID_W-1:0] map_id(input logic [CLASS_W-1:0] cls,
			input logic color);
		logic [ID_W-1:0] real_id;
		real_id = ID_NONE;
		case (cls) inside
			[8'd1:8'd5]: begin
				real_id = cls;
			end
			CLASS_REMAP: begin
				real_id = ID_REMAP;
			end
			default: begin
				real_id = ID_NONE;
			end
		endcase
		if (cls == CLASS_UNKNOWN) begin
			map_id = CLASS_UNKNOWN;
		end else if (color) begin
			map_id = real_id;
		end else begin
			map_id = real_id + ID_OFFSET;
		end
	endfunction

endpackage

FILE: hw/rtl/pixel_depth_to_map_point.sv
// pixel_depth_to_map_point: eight stage back-projection of a detection onto
// the normalized field map, with id mapping and team filter
// depends on pdmp_pkg
//
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-----------------------------------
// s_*       | in        | s_tvalid/s_tready  | tdata px, py, dist, class; tuser color
// m_*       | out       | m_tvalid/m_tready  | tdata map_x, map_y, robot_id
// cfg_*     | in        | cfg_we             | cfg_index, cfg_wdata (64 bit)
//
// one word per cycle in unless a full pipeline is held by m_tready; kept words pass stages s1 to s8 to m_tvalid
// words with zero distance or of the own team never enter the pipeline
// each stage holds while its successor is full and cannot advance; bubbles are squeezed out
// arst_n clears valid bits and registers; stage payloads are not reset
`timescale 1ns / 1ps

module pixel_depth_to_map_point #(
	parameter int COEF_FRAC  = pdmp_pkg::COEF_FRAC_DEF,
	parameter int PIXEL_BITS = pdmp_pkg::PIXEL_BITS_DEF,
	parameter int DIST_BITS  = pdmp_pkg::DIST_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// pixel_x, pixel_y, dist_mm, detector_class, zero fill
	input  logic [((2*PIXEL_BITS+DIST_BITS+pdmp_pkg::CLASS_W+7)/8)*8-1:0] s_tdata,
	// target_color
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// map_x, map_y, robot_id
	output logic [pdmp_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [pdmp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pdmp_pkg::REG_W-1:0] cfg_wdata
);

	localparam int SH     = COEF_FRAC - pdmp_pkg::Q16_BITS;
	localparam int CW     = pdmp_pkg::COEF_W;
	localparam int PROD_W = CW + PIXEL_BITS + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int MAG_W  = SUM_W;
	localparam int HI_W   = MAG_W - CW;
	localparam int LO_P_W = CW + DIST_BITS;
	localparam int HI_P_W = HI_W + DIST_BITS;
	localparam int PW     = MAG_W + DIST_BITS;
	localparam int QX_W   = (PW - SH > pdmp_pkg::CAP_BITS + 2) ? PW - SH
		: pdmp_pkg::CAP_BITS + 2;
	localparam int QR_W   = pdmp_pkg::CAP_BITS + 1;
	localparam int V_W    = pdmp_pkg::CAP_BITS + 3;
	localparam int W_W    = V_W + 1;
	localparam int CO_W   = pdmp_pkg::COORD_W;
	localparam int ID_W   = pdmp_pkg::ID_W;
	localparam int NST    = 8;

	localparam logic [QX_W-1:0] CAP = {{(QX_W-pdmp_pkg::CAP_BITS-1){1'b0}}, 1'b1,
		{pdmp_pkg::CAP_BITS{1'b0}}};
	localparam logic signed [W_W-1:0] FLIP_ONE = W_W'(pdmp_pkg::FLIP_ONE);
	localparam logic signed [W_W-1:0] SAT_HI   = W_W'(pdmp_pkg::OUT_MAX);
	localparam logic signed [W_W-1:0] SAT_LO   = W_W'(pdmp_pkg::OUT_MIN);

	// input fields
	logic [PIXEL_BITS-1:0] pixel_x, pixel_y;
	logic [DIST_BITS-1:0] dist_mm;
	logic [pdmp_pkg::CLASS_W-1:0] detector_class;
	logic target_color;
	logic [ID_W-1:0] in_id;
	logic in_keep;

	assign pixel_x        = s_tdata[PIXEL_BITS-1:0];
	assign pixel_y        = s_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
	assign dist_mm        = s_tdata[2*PIXEL_BITS+DIST_BITS-1:2*PIXEL_BITS];
	assign detector_class = s_tdata[2*PIXEL_BITS+DIST_BITS+pdmp_pkg::CLASS_W-1:
		2*PIXEL_BITS+DIST_BITS];
	assign target_color   = s_tuser;

	// registers
	logic [pdmp_pkg::REG_W-1:0] xy_q [2];
	logic [pdmp_pkg::REG_W-1:0] co_q [2];
	logic blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xy_q[0] <= '0;
			xy_q[1] <= '0;
			co_q[0] <= '0;
			co_q[1] <= '0;
			blue_q  <= 1'b0;
		end else if (cfg_we) begin
			case (pdmp_pkg::cfg_reg_t'(cfg_index))
				pdmp_pkg::REG_X_XY: begin
					xy_q[0] <= cfg_wdata;
				end
				pdmp_pkg::REG_X_CO: begin
					co_q[0] <= cfg_wdata;
				end
				pdmp_pkg::REG_Y_XY: begin
					xy_q[1] <= cfg_wdata;
				end
				pdmp_pkg::REG_Y_CO: begin
					co_q[1] <= cfg_wdata;
				end
				pdmp_pkg::REG_BLUE: begin
					blue_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	logic signed [CW-1:0] c0 [2];
	logic signed [CW-1:0] c1 [2];
	logic signed [CW-1:0] c2 [2];
	logic signed [CW-1:0] off [2];

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			c0[r]  = signed'(xy_q[r][CW-1:0]);
			c1[r]  = signed'(xy_q[r][2*CW-1:CW]);
			c2[r]  = signed'(co_q[r][CW-1:0]);
			off[r] = signed'(co_q[r][2*CW-1:CW]);
		end
	end

	assign in_id   = pdmp_pkg::map_id(detector_class, target_color);
	assign in_keep = (dist_mm != '0) && (blue_q ? (in_id < pdmp_pkg::ID_OFFSET)
		: (in_id >= pdmp_pkg::ID_OFFSET));

	// stage advance chain
	logic [NST:1] vld;
	logic [NST+1:1] adv;

	always_comb begin
		adv[NST+1] = m_tready;
		for (int k = NST; k >= 1; k--) begin
			adv[k] = !vld[k] || adv[k+1];
		end
	end

	assign s_tready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv[1]) begin
				vld[1] <= s_tvalid && in_keep;
			end
			for (int k = 2; k <= NST; k++) begin
				if (adv[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// stage payloads
	logic signed [PROD_W-1:0] p0_s1 [2];
	logic signed [PROD_W-1:0] p1_s1 [2];
	logic [DIST_BITS-1:0] d_s1, d_s2, d_s3;
	logic [ID_W-1:0] id_s1, id_s2, id_s3, id_s4, id_s5, id_s6, id_s7, id_s8;
	logic signed [SUM_W-1:0] sum_s2 [2];
	logic [MAG_W-1:0] mag_s3 [2];
	logic neg_s3 [2];
	logic neg_s4 [2];
	logic neg_s5 [2];
	logic neg_s6 [2];
	logic [LO_P_W-1:0] lo_s4 [2];
	logic [HI_P_W-1:0] hi_s4 [2];
	logic [PW-1:0] p_s5 [2];
	logic [QR_W-1:0] qr_s6 [2];
	logic signed [V_W-1:0] v_s7 [2];
	logic [CO_W-1:0] map_s8 [2];

	logic [QX_W-1:0] qx_c [2];
	logic [QR_W-1:0] q_c [2];
	logic rem_c [2];
	logic signed [V_W-1:0] qs_c [2];
	logic signed [W_W-1:0] w_c [2];
	logic [CO_W-1:0] sat_c [2];

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			qx_c[r]  = QX_W'(p_s5[r] >> SH);
			q_c[r]   = (qx_c[r] > CAP) ? CAP[QR_W-1:0] : qx_c[r][QR_W-1:0];
			rem_c[r] = |p_s5[r][SH-1:0];
			qs_c[r]  = signed'(V_W'(qr_s6[r]));
			w_c[r]   = blue_q ? (FLIP_ONE - W_W'(v_s7[r])) : W_W'(v_s7[r]);
			if (w_c[r] > SAT_HI) begin
				sat_c[r] = SAT_HI[CO_W-1:0];
			end else if (w_c[r] < SAT_LO) begin
				sat_c[r] = SAT_LO[CO_W-1:0];
			end else begin
				sat_c[r] = w_c[r][CO_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int r = 0; r < 2; r++) begin
				p0_s1[r] <= PROD_W'(c0[r]) * PROD_W'(signed'({1'b0, pixel_x}));
				p1_s1[r] <= PROD_W'(c1[r]) * PROD_W'(signed'({1'b0, pixel_y}));
			end
			d_s1  <= dist_mm;
			id_s1 <= in_id;
		end
		if (adv[2]) begin
			for (int r = 0; r < 2; r++) begin
				sum_s2[r] <= SUM_W'(p0_s1[r]) + SUM_W'(p1_s1[r]) + SUM_W'(c2[r]);
			end
			d_s2  <= d_s1;
			id_s2 <= id_s1;
		end
		if (adv[3]) begin
			for (int r = 0; r < 2; r++) begin
				neg_s3[r] <= sum_s2[r][SUM_W-1];
				mag_s3[r] <= sum_s2[r][SUM_W-1] ? MAG_W'(-sum_s2[r]) : MAG_W'(sum_s2[r]);
			end
			d_s3  <= d_s2;
			id_s3 <= id_s2;
		end
		if (adv[4]) begin
			for (int r = 0; r < 2; r++) begin
				lo_s4[r]  <= LO_P_W'(mag_s3[r][CW-1:0]) * LO_P_W'(d_s3);
				hi_s4[r]  <= HI_P_W'(mag_s3[r][MAG_W-1:CW]) * HI_P_W'(d_s3);
				neg_s4[r] <= neg_s3[r];
			end
			id_s4 <= id_s3;
		end
		if (adv[5]) begin
			for (int r = 0; r < 2; r++) begin
				p_s5[r]   <= (PW'(hi_s4[r]) << CW) + PW'(lo_s4[r]);
				neg_s5[r] <= neg_s4[r];
			end
			id_s5 <= id_s4;
		end
		if (adv[6]) begin
			for (int r = 0; r < 2; r++) begin
				qr_s6[r]  <= q_c[r] + QR_W'(neg_s5[r] && rem_c[r]);
				neg_s6[r] <= neg_s5[r];
			end
			id_s6 <= id_s5;
		end
		if (adv[7]) begin
			for (int r = 0; r < 2; r++) begin
				v_s7[r] <= (neg_s6[r] ? -qs_c[r] : qs_c[r]) - V_W'(off[r]);
			end
			id_s7 <= id_s6;
		end
		if (adv[8]) begin
			for (int r = 0; r < 2; r++) begin
				map_s8[r] <= sat_c[r];
			end
			id_s8 <= id_s7;
		end
	end

	assign m_tvalid = vld[NST];
	assign m_tdata  = {id_s8, map_s8[1], map_s8[0]};

endmodule
